### design/hkfc_pkg.sv
// Shared constants, types and the leader update function of the frequency counter.
package hkfc_pkg;

   localparam int PHONE_W        = 37;
   localparam int COUNT_W        = 16;
   localparam int TIES_W         = 13;
   localparam int PHONE_DIGITS   = 11;
   localparam int LOW_DIGITS     = 5;
   localparam int LOW_MOD        = 10 ** LOW_DIGITS;
   localparam int LOW_W          = $clog2(LOW_MOD);
   localparam int BUCKETS_DEF    = 1021;
   localparam int POOL_DEF       = 4096;

   // Byte weights of the number modulo 100000; the weighted byte sum fits FOLD_W bits
   localparam int FOLD_W         = 26;
   localparam int FOLD_K1        = (1 << 8) % LOW_MOD;
   localparam int FOLD_K2        = (1 << 16) % LOW_MOD;
   localparam int FOLD_K3        = int'((longint'(1) << 24) % LOW_MOD);
   localparam int FOLD_K4        = int'((longint'(1) << 32) % LOW_MOD);

   // Reciprocal of 100000, exact for every FOLD_W-bit sum
   localparam int     LOW_SHIFT   = FOLD_W + LOW_W;
   localparam longint LOW_RECIP   = ((longint'(1) << LOW_SHIFT) + longint'(LOW_MOD) - 1)
                                    / longint'(LOW_MOD);
   localparam int     LOW_RECIP_W = $clog2(LOW_RECIP + 1);

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [TIES_W-1:0]  TIES_MAX  = '1;

   // Front: take a request, reduce the number to its bucket, hand it on
   typedef enum logic [2:0] {
      F_IDLE,
      F_FOLD,
      F_LOW_Q,
      F_LOW,
      F_BKT_Q,
      F_BKT,
      F_PUSH
   } front_state_type;

   // Back: clearing pass, then chain walk and update per request
   typedef enum logic [2:0] {
      B_CLEAR,
      B_IDLE,
      B_HEAD,
      B_ENTRY,
      B_ALLOC,
      B_RESULT
   } back_state_type;

   typedef struct packed {
      logic [PHONE_W-1:0] phone;
      logic [COUNT_W-1:0] count;
      logic [TIES_W-1:0]  ties;
   } leader_type;

   // Fold one updated count into the running leader
   function automatic leader_type note_count(leader_type cur, logic [PHONE_W-1:0] ph,
                                             logic [COUNT_W-1:0] cnt);
      leader_type res;
      res = cur;
      if (cnt > cur.count) begin
         res.count = cnt;
         res.phone = ph;
         res.ties  = TIES_W'(1);
      end else if (cnt == cur.count) begin
         if (cur.ties < TIES_MAX) begin
            res.ties = cur.ties + TIES_W'(1);
         end
         if (ph < cur.phone) begin
            res.phone = ph;
         end
      end
      return res;
   endfunction

endpackage

### design/hkfc_if.sv
// Request and response channel interfaces of the frequency counter.
interface hkfc_req_if
   import hkfc_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic [PHONE_W-1:0] phone;

   modport source (output valid, output phone, input ready);
   modport sink (input valid, input phone, output ready);
endinterface

interface hkfc_rsp_if
   import hkfc_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic               is_new;
   logic               table_full;
   logic [COUNT_W-1:0] phone_count;
   logic [PHONE_W-1:0] leader_phone;
   logic [COUNT_W-1:0] leader_count;
   logic [TIES_W-1:0]  tie_count;

   modport source (output valid, output is_new, output table_full, output phone_count,
                   output leader_phone, output leader_count, output tie_count,
                   input ready);
   modport sink (input valid, input is_new, input table_full, input phone_count,
                 input leader_phone, input leader_count, input tie_count,
                 output ready);
endinterface

### design/hashed_key_frequency_counter.sv
// Top level of the hashed phone number frequency counter.
//
//   Channel   Modport   Payload
//   req_chan  sink      phone
//   rsp_chan  source    is_new, table_full, phone_count, leader_phone, leader_count, tie_count
//
// The front takes one request at a time: it takes it, folds the bytes into a residue sum,
// takes the modulo by 100000 and then by the bucket count, each as a quotient and a remainder
// step, and queues the pair, waiting while the queue is full. The back pops a request, reads
// the bucket head, walks the chain a link at a time, allocates an entry for a new number and
// loads the response register. After reset a clearing pass writes all BUCKETS bucket heads
// (1021 by default), during which no request is taken. A stalled response holds the back; the
// two-deep queue lets the front keep hashing meanwhile.
module hashed_key_frequency_counter
   import hkfc_pkg::*;
#(
   parameter int BUCKETS      = BUCKETS_DEF,
   parameter int POOL_ENTRIES = POOL_DEF
) (
   input  logic       clock,
   input  logic       reset,
   hkfc_req_if.sink   req_chan,
   hkfc_rsp_if.source rsp_chan
);

   localparam int BKT_W = $clog2(BUCKETS);
   localparam int Q_W   = PHONE_W + BKT_W;

   logic               clearing;
   logic               push, pop, q_full, q_empty;
   logic [PHONE_W-1:0] push_phone;
   logic [BKT_W-1:0]   push_bucket;
   logic [Q_W-1:0]     pop_data;

   hkfc_front #(.BUCKETS(BUCKETS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .clearing    (clearing),
      .push        (push),
      .push_phone  (push_phone),
      .push_bucket (push_bucket),
      .queue_full  (q_full)
   );

   hkfc_queue #(.WIDTH(Q_W)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_phone, push_bucket}),
      .full      (q_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   hkfc_back #(.BUCKETS(BUCKETS), .POOL_ENTRIES(POOL_ENTRIES)) u_back (
      .clock        (clock),
      .reset        (reset),
      .clearing     (clearing),
      .queue_empty  (q_empty),
      .queue_phone  (pop_data[Q_W-1 -: PHONE_W]),
      .queue_bucket (pop_data[BKT_W-1:0]),
      .pop          (pop),
      .rsp_chan     (rsp_chan)
   );

endmodule

### design/hkfc_ram.sv
// Generic single write, single read RAM with registered read data.
module hkfc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/hkfc_queue.sv
// Two-deep queue between the hashing front and the table back.
module hkfc_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   logic [WIDTH-1:0] data_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;
   logic             do_push, do_pop;

   assign full     = (fill_ff == 2'd2);
   assign empty    = (fill_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = data_ff[rd_ptr_ff];

   // Pointer and fill level update
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### design/hkfc_front.sv
// Front end: accepts requests and reduces each number to its bucket.
module hkfc_front
   import hkfc_pkg::*;
#(
   parameter int BUCKETS = BUCKETS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   hkfc_req_if.sink                      req_chan,
   input  logic                          clearing,
   output logic                          push,
   output logic [PHONE_W-1:0]            push_phone,
   output logic [$clog2(BUCKETS)-1:0]    push_bucket,
   input  logic                          queue_full
);

   localparam int     BKT_W       = $clog2(BUCKETS);
   localparam int     BKT_SHIFT   = LOW_W + BKT_W;
   localparam longint BKT_RECIP   = ((longint'(1) << BKT_SHIFT) + longint'(BUCKETS) - 1)
                                    / longint'(BUCKETS);
   localparam int     BKT_RECIP_W = $clog2(BKT_RECIP + 1);
   localparam int     LOW_PROD_W  = FOLD_W + LOW_RECIP_W;
   localparam int     LOW_Q_W     = LOW_PROD_W - LOW_SHIFT;
   localparam int     BKT_PROD_W  = LOW_W + BKT_RECIP_W;
   localparam int     BKT_Q_W     = BKT_PROD_W - BKT_SHIFT;

   front_state_type     state_ff, state_in;
   logic [PHONE_W-1:0]  phone_ff, phone_in;
   logic [FOLD_W-1:0]   acc_ff, acc_in;
   logic [LOW_Q_W-1:0]  lowq_ff, lowq_in;
   logic [LOW_W-1:0]    low_ff, low_in;
   logic [BKT_Q_W-1:0]  bktq_ff, bktq_in;
   logic [BKT_W-1:0]    bkt_ff, bkt_in;
   logic [FOLD_W-1:0]   fold_sum;
   logic [LOW_PROD_W-1:0] low_prod;
   logic [BKT_PROD_W-1:0] bkt_prod;
   logic                accept;

   assign accept = req_chan.valid && req_chan.ready;

   // Byte chunks weighted by their place value modulo 100000
   assign fold_sum = FOLD_W'(phone_ff[7:0])
                   + FOLD_W'(phone_ff[15:8]) * FOLD_W'(FOLD_K1)
                   + FOLD_W'(phone_ff[23:16]) * FOLD_W'(FOLD_K2)
                   + FOLD_W'(phone_ff[31:24]) * FOLD_W'(FOLD_K3)
                   + FOLD_W'(phone_ff[PHONE_W-1:32]) * FOLD_W'(FOLD_K4);

   // Quotients by reciprocal multiplication, exact over the operand ranges
   assign low_prod = LOW_PROD_W'(acc_ff) * LOW_PROD_W'(LOW_RECIP);
   assign bkt_prod = BKT_PROD_W'(low_ff) * BKT_PROD_W'(BKT_RECIP);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE:  if (accept) state_in = F_FOLD;
         F_FOLD:  state_in = F_LOW_Q;
         F_LOW_Q: state_in = F_LOW;
         F_LOW:   state_in = F_BKT_Q;
         F_BKT_Q: state_in = F_BKT;
         F_BKT:   state_in = F_PUSH;
         F_PUSH:  if (!queue_full) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      phone_in       = phone_ff;
      acc_in         = acc_ff;
      lowq_in        = lowq_ff;
      low_in         = low_ff;
      bktq_in        = bktq_ff;
      bkt_in         = bkt_ff;
      req_chan.ready = 1'b0;
      push           = 1'b0;
      case (state_ff)
         F_IDLE: begin
            req_chan.ready = !clearing;
            if (accept) begin
               phone_in = req_chan.phone;
            end
         end
         F_FOLD:  acc_in  = fold_sum;
         F_LOW_Q: lowq_in = low_prod[LOW_PROD_W-1:LOW_SHIFT];
         F_LOW:   low_in  = LOW_W'(acc_ff - FOLD_W'(lowq_ff) * FOLD_W'(LOW_MOD));
         F_BKT_Q: bktq_in = bkt_prod[BKT_PROD_W-1:BKT_SHIFT];
         F_BKT:   bkt_in  = BKT_W'(low_ff - LOW_W'(bktq_ff) * LOW_W'(BUCKETS));
         F_PUSH:  push    = 1'b1;
         default: ;
      endcase
   end

   assign push_phone  = phone_ff;
   assign push_bucket = bkt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      phone_ff <= phone_in;
      acc_ff   <= acc_in;
      lowq_ff  <= lowq_in;
      low_ff   <= low_in;
      bktq_ff  <= bktq_in;
      bkt_ff   <= bkt_in;
   end

endmodule

### design/hkfc_back.sv
// Back end: clears the buckets, walks a chain, updates counts and the leader, drives results.
module hkfc_back
   import hkfc_pkg::*;
#(
   parameter int BUCKETS      = BUCKETS_DEF,
   parameter int POOL_ENTRIES = POOL_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   output logic                          clearing,
   input  logic                          queue_empty,
   input  logic [PHONE_W-1:0]            queue_phone,
   input  logic [$clog2(BUCKETS)-1:0]    queue_bucket,
   output logic                          pop,
   hkfc_rsp_if.source                    rsp_chan
);

   localparam int BKT_W   = $clog2(BUCKETS);
   localparam int LINK_W  = $clog2(POOL_ENTRIES + 1);
   localparam int IDX_W   = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
   localparam int ENTRY_W = PHONE_W + COUNT_W + LINK_W;

   back_state_type     state_ff, state_in;
   logic [BKT_W-1:0]   clr_ff, clr_in;
   logic [PHONE_W-1:0] phone_ff, phone_in;
   logic [BKT_W-1:0]   bucket_ff, bucket_in;
   logic [LINK_W-1:0]  head_ff, head_in;
   logic [IDX_W-1:0]   cur_ff, cur_in;
   logic [LINK_W-1:0]  used_ff, used_in;
   leader_type         best_ff, best_in;
   logic               res_new_ff, res_new_in;
   logic               res_full_ff, res_full_in;
   logic [COUNT_W-1:0] res_cnt_ff, res_cnt_in;
   logic               out_valid_ff, out_valid_in;
   logic               out_new_ff, out_new_in;
   logic               out_full_ff, out_full_in;
   logic [COUNT_W-1:0] out_cnt_ff, out_cnt_in;
   leader_type         out_best_ff, out_best_in;

   // Memory ports
   logic               bkt_wr_en, bkt_rd_en;
   logic [BKT_W-1:0]   bkt_wr_addr, bkt_rd_addr;
   logic [LINK_W-1:0]  bkt_wr_data, bkt_rd_data;
   logic               ent_wr_en, ent_rd_en;
   logic [IDX_W-1:0]   ent_wr_addr, ent_rd_addr;
   logic [ENTRY_W-1:0] ent_wr_data, ent_rd_data;

   logic [PHONE_W-1:0] e_phone;
   logic [COUNT_W-1:0] e_count;
   logic [LINK_W-1:0]  e_next;
   logic [COUNT_W-1:0] inc_count;
   logic [LINK_W-1:0]  head_m1, next_m1;

   assign e_phone   = ent_rd_data[ENTRY_W-1 -: PHONE_W];
   assign e_count   = ent_rd_data[LINK_W +: COUNT_W];
   assign e_next    = ent_rd_data[LINK_W-1:0];
   assign inc_count = e_count + COUNT_W'(1);
   assign head_m1   = bkt_rd_data - LINK_W'(1);
   assign next_m1   = e_next - LINK_W'(1);
   assign clearing  = (state_ff == B_CLEAR);

   hkfc_ram #(.WIDTH(LINK_W), .DEPTH(BUCKETS)) u_bucket_ram (
      .clock   (clock),
      .wr_en   (bkt_wr_en),
      .wr_addr (bkt_wr_addr),
      .wr_data (bkt_wr_data),
      .rd_en   (bkt_rd_en),
      .rd_addr (bkt_rd_addr),
      .rd_data (bkt_rd_data)
   );

   hkfc_ram #(.WIDTH(ENTRY_W), .DEPTH(POOL_ENTRIES)) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (ent_wr_addr),
      .wr_data (ent_wr_data),
      .rd_en   (ent_rd_en),
      .rd_addr (ent_rd_addr),
      .rd_data (ent_rd_data)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_CLEAR: if (clr_ff == BKT_W'(BUCKETS - 1)) state_in = B_IDLE;
         B_IDLE:  if (!queue_empty) state_in = B_HEAD;
         B_HEAD:  state_in = (bkt_rd_data == '0) ? B_ALLOC : B_ENTRY;
         B_ENTRY: begin
            if (e_phone == phone_ff) begin
               state_in = B_RESULT;
            end else if (e_next == '0) begin
               state_in = B_ALLOC;
            end
         end
         B_ALLOC:  state_in = B_RESULT;
         B_RESULT: if (!out_valid_ff || rsp_chan.ready) state_in = B_IDLE;
         default:  state_in = B_IDLE;
      endcase
   end

   // Datapath, memory controls and result register
   always_comb begin
      clr_in       = clr_ff;
      phone_in     = phone_ff;
      bucket_in    = bucket_ff;
      head_in      = head_ff;
      cur_in       = cur_ff;
      used_in      = used_ff;
      best_in      = best_ff;
      res_new_in   = res_new_ff;
      res_full_in  = res_full_ff;
      res_cnt_in   = res_cnt_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_new_in   = out_new_ff;
      out_full_in  = out_full_ff;
      out_cnt_in   = out_cnt_ff;
      out_best_in  = out_best_ff;
      pop          = 1'b0;
      bkt_wr_en    = 1'b0;
      bkt_wr_addr  = bucket_ff;
      bkt_wr_data  = '0;
      bkt_rd_en    = 1'b0;
      bkt_rd_addr  = queue_bucket;
      ent_wr_en    = 1'b0;
      ent_wr_addr  = cur_ff;
      ent_wr_data  = {phone_ff, inc_count, e_next};
      ent_rd_en    = 1'b0;
      ent_rd_addr  = head_m1[IDX_W-1:0];
      case (state_ff)
         B_CLEAR: begin
            bkt_wr_en   = 1'b1;
            bkt_wr_addr = clr_ff;
            clr_in      = clr_ff + BKT_W'(1);
         end
         B_IDLE: begin
            if (!queue_empty) begin
               pop       = 1'b1;
               bkt_rd_en = 1'b1;
               phone_in  = queue_phone;
               bucket_in = queue_bucket;
            end
         end
         B_HEAD: begin
            head_in = bkt_rd_data;
            if (bkt_rd_data != '0) begin
               ent_rd_en = 1'b1;
               cur_in    = head_m1[IDX_W-1:0];
            end
         end
         B_ENTRY: begin
            if (e_phone == phone_ff) begin
               res_new_in  = 1'b0;
               res_full_in = 1'b0;
               res_cnt_in  = e_count;
               if (e_count < COUNT_MAX) begin
                  ent_wr_en  = 1'b1;
                  res_cnt_in = inc_count;
                  best_in    = note_count(best_ff, phone_ff, inc_count);
               end
            end else if (e_next != '0) begin
               ent_rd_en   = 1'b1;
               ent_rd_addr = next_m1[IDX_W-1:0];
               cur_in      = next_m1[IDX_W-1:0];
            end
         end
         B_ALLOC: begin
            res_new_in = 1'b1;
            if (used_ff >= LINK_W'(POOL_ENTRIES)) begin
               res_full_in = 1'b1;
               res_cnt_in  = '0;
            end else begin
               res_full_in = 1'b0;
               res_cnt_in  = COUNT_W'(1);
               ent_wr_en   = 1'b1;
               ent_wr_addr = used_ff[IDX_W-1:0];
               ent_wr_data = {phone_ff, COUNT_W'(1), head_ff};
               bkt_wr_en   = 1'b1;
               bkt_wr_data = used_ff + LINK_W'(1);
               used_in     = used_ff + LINK_W'(1);
               best_in     = note_count(best_ff, phone_ff, COUNT_W'(1));
            end
         end
         B_RESULT: begin
            if (!out_valid_ff || rsp_chan.ready) begin
               out_valid_in = 1'b1;
               out_new_in   = res_new_ff;
               out_full_in  = res_full_ff;
               out_cnt_in   = res_cnt_ff;
               out_best_in  = best_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.is_new       = out_new_ff;
   assign rsp_chan.table_full   = out_full_ff;
   assign rsp_chan.phone_count  = out_cnt_ff;
   assign rsp_chan.leader_phone = out_best_ff.phone;
   assign rsp_chan.leader_count = out_best_ff.count;
   assign rsp_chan.tie_count    = out_best_ff.ties;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         used_ff      <= '0;
         best_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         used_ff      <= used_in;
         best_ff      <= best_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      phone_ff    <= phone_in;
      bucket_ff   <= bucket_in;
      head_ff     <= head_in;
      cur_ff      <= cur_in;
      res_new_ff  <= res_new_in;
      res_full_ff <= res_full_in;
      res_cnt_ff  <= res_cnt_in;
      out_new_ff  <= out_new_in;
      out_full_ff <= out_full_in;
      out_cnt_ff  <= out_cnt_in;
      out_best_ff <= out_best_in;
   end

endmodule

### sim/tb_hashed_key_frequency_counter.sv
// Self-checking testbench of the hashed phone number frequency counter.
module tb_hashed_key_frequency_counter;
   import hkfc_pkg::*;

   localparam int NBKT      = BUCKETS_DEF;
   localparam int NPOOL     = POOL_DEF;
   localparam int WDOG_MAX  = 20000;
   localparam int HOLD_CYCLES = 600;
   localparam longint unsigned PHONE_TOP = 64'd99999999999;

   typedef struct packed {
      logic               is_new;
      logic               table_full;
      logic [COUNT_W-1:0] phone_count;
      logic [PHONE_W-1:0] leader_phone;
      logic [COUNT_W-1:0] leader_count;
      logic [TIES_W-1:0]  tie_count;
   } tally_type;

   typedef struct {
      logic [PHONE_W-1:0] phone;
      bit                 typed;
      tally_type          tally;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hkfc_req_if req_chan ();
   hkfc_rsp_if rsp_chan ();

   hashed_key_frequency_counter dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always #5 clock = ~clock;

   // Predictor state: numbers seen, with their counts, and the running leader
   longint unsigned phone_book [$];
   int unsigned     phone_tally [longint unsigned];
   int unsigned     stored_numbers;
   longint unsigned lead_phone;
   int unsigned     lead_count;
   int unsigned     lead_ties;

   tally_type expected_tallies [$];
   tally_type typed_tallies [$];
   bit        typed_marks [$];
   int        error_count = 0;
   int        idle_cycles = 0;
   int        send_idle_pct;
   int        recv_stall_pct;
   bit        hold_start = 1'b0;
   bit        hold_taken = 1'b0;
   int        hold_left = 0;

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic void fold_leader(longint unsigned ph, int unsigned cnt);
      if (cnt > lead_count) begin
         lead_count = cnt;
         lead_phone = ph;
         lead_ties  = 1;
      end else if (cnt == lead_count) begin
         if (lead_ties < 8191) lead_ties++;
         if (ph < lead_phone) lead_phone = ph;
      end
   endfunction

   // Expected result for one request; the pool order does not affect results
   function automatic tally_type count_phone(logic [PHONE_W-1:0] phone);
      tally_type t;
      longint unsigned ph;
      ph = 64'(phone);
      t  = '0;
      if (phone_tally.exists(ph)) begin
         if (phone_tally[ph] < 65535) begin
            phone_tally[ph]++;
            fold_leader(ph, phone_tally[ph]);
         end
         t.phone_count = COUNT_W'(phone_tally[ph]);
      end else begin
         t.is_new = 1'b1;
         if (stored_numbers >= NPOOL) begin
            t.table_full = 1'b1;
         end else begin
            phone_tally[ph] = 1;
            phone_book.push_back(ph);
            stored_numbers++;
            fold_leader(ph, 1);
            t.phone_count = COUNT_W'(1);
         end
      end
      t.leader_phone = PHONE_W'(lead_phone);
      t.leader_count = COUNT_W'(lead_count);
      t.tie_count    = TIES_W'(lead_ties);
      return t;
   endfunction

   // Offer one request, idling at random beforehand
   task automatic send_request(input logic [PHONE_W-1:0] phone, input bit typed,
                               input tally_type want);
      tally_type t;
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.phone <= phone;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      t = count_phone(phone);
      expected_tallies.push_back(t);
      typed_marks.push_back(typed);
      typed_tallies.push_back(want);
      @(negedge clock);
   endtask

   function automatic logic [PHONE_W-1:0] random_phone();
      longint unsigned hi;
      hi = {$urandom, $urandom};
      return PHONE_W'(hi);
   endfunction

   // Number sharing one of a few buckets, to build long chains
   function automatic logic [PHONE_W-1:0] chained_phone();
      longint unsigned ph;
      ph = longint'($urandom_range(3)) + longint'(NBKT) * $urandom_range(97)
           + 64'd100000 * $urandom_range(999999);
      return PHONE_W'(ph % (PHONE_TOP + 1));
   endfunction

   // Receiver: accept responses and compare with the oldest expectation
   always @(posedge clock) begin
      tally_type want;
      tally_type typed_want;
      tally_type got;
      bit        typed;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_tallies.size() == 0) begin
            report_mismatch("unexpected response", 64'(1), 64'(0));
         end else begin
            want       = expected_tallies.pop_front();
            typed      = typed_marks.pop_front();
            typed_want = typed_tallies.pop_front();
            got = {rsp_chan.is_new, rsp_chan.table_full, rsp_chan.phone_count,
                   rsp_chan.leader_phone, rsp_chan.leader_count, rsp_chan.tie_count};
            if (typed && got !== typed_want)
               report_mismatch("typed row", 64'(got), 64'(typed_want));
            if (rsp_chan.is_new !== want.is_new)
               report_mismatch("is_new", 64'(rsp_chan.is_new), 64'(want.is_new));
            if (rsp_chan.table_full !== want.table_full)
               report_mismatch("table_full", 64'(rsp_chan.table_full), 64'(want.table_full));
            if (rsp_chan.phone_count !== want.phone_count)
               report_mismatch("phone_count", 64'(rsp_chan.phone_count),
                               64'(want.phone_count));
            if (rsp_chan.leader_phone !== want.leader_phone)
               report_mismatch("leader_phone", 64'(rsp_chan.leader_phone),
                               64'(want.leader_phone));
            if (rsp_chan.leader_count !== want.leader_count)
               report_mismatch("leader_count", 64'(rsp_chan.leader_count),
                               64'(want.leader_count));
            if (rsp_chan.tie_count !== want.tie_count)
               report_mismatch("tie_count", 64'(rsp_chan.tie_count), 64'(want.tie_count));
         end
      end
   end

   // Receiver stall pattern, with one long hold-off counted here
   always @(negedge clock) begin
      if (hold_start && !hold_taken) begin
         hold_taken     <= 1'b1;
         hold_left      <= HOLD_CYCLES;
         rsp_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left      <= hold_left - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog on cycles with no request or response moving
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles > WDOG_MAX + (reset ? 0 : NBKT)) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin
      stim_row_type directed [$];
      stim_row_type row;
      tally_type    t;
      int           n;
      longint unsigned ph;

      req_chan.valid  = 1'b0;
      req_chan.phone  = '0;
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      stored_numbers  = 0;
      lead_phone = 0; lead_count = 0; lead_ties = 0;

      // Directed table; typed rows are read off directly
      t = '0; t.is_new = 1; t.phone_count = 1; t.leader_count = 1; t.tie_count = 1;
      t.leader_phone = 0;
      directed.push_back('{PHONE_W'(0), 1'b1, t});
      t.phone_count = 2; t.is_new = 0; t.leader_count = 2;
      directed.push_back('{PHONE_W'(0), 1'b1, t});
      directed.push_back('{PHONE_W'(PHONE_TOP), 1'b0, '0});
      directed.push_back('{'1, 1'b0, '0});
      directed.push_back('{PHONE_W'(64'd12345678901), 1'b0, '0});
      directed.push_back('{PHONE_W'(64'd12345678901), 1'b0, '0});
      directed.push_back('{PHONE_W'(64'd12345678901), 1'b0, '0});
      // Same bucket as zero: multiples of the bucket count and of 100000
      directed.push_back('{PHONE_W'(NBKT), 1'b0, '0});
      directed.push_back('{PHONE_W'(100000), 1'b0, '0});
      directed.push_back('{PHONE_W'(2 * NBKT), 1'b0, '0});
      directed.push_back('{PHONE_W'(100000), 1'b0, '0});
      directed.push_back('{PHONE_W'(NBKT), 1'b0, '0});
      directed.push_back('{PHONE_W'(64'h1555555555), 1'b0, '0});
      directed.push_back('{PHONE_W'(64'h0AAAAAAAAA), 1'b0, '0});
      directed.push_back('{PHONE_W'(1), 1'b0, '0});
      directed.push_back('{PHONE_W'(0), 1'b0, '0});

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) begin
         row = directed[i];
         send_request(row.phone, row.typed, row.tally);
      end

      // Random phases: no idling, sender idle, receiver stalling, both
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = (phase == 1) ? 75 : (phase == 3) ? 30 : 0;
         recv_stall_pct = (phase == 2) ? 75 : (phase == 3) ? 30 : 0;
         if (phase == 2) hold_start = 1'b1;
         for (n = 0; n < 135; n++) begin
            case ($urandom_range(9))
               0, 1, 2, 3: begin
                  ph = phone_book.size() ? phone_book[$urandom_range(phone_book.size() - 1)]
                                         : 0;
                  send_request(PHONE_W'(ph), 1'b0, '0);
               end
               4, 5:    send_request(chained_phone(), 1'b0, '0);
               6:       send_request(random_phone(), 1'b0, '0);
               default: send_request(PHONE_W'({$urandom, $urandom} % (PHONE_TOP + 1)),
                                     1'b0, '0);
            endcase
         end
      end

      req_chan.valid <= 1'b0;
      recv_stall_pct = 0;
      while (expected_tallies.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

### sim.f
design/hkfc_pkg.sv
design/hkfc_if.sv
design/hkfc_ram.sv
design/hkfc_queue.sv
design/hkfc_front.sv
design/hkfc_back.sv
design/hashed_key_frequency_counter.sv
sim/tb_hashed_key_frequency_counter.sv
